[sv/oos_pkg.sv]
// oos_pkg: constants, status codes and the saturation helper shared by the
// on/off significance pipeline. No dependencies.

package oos_pkg;

   localparam int COUNT_BITS_DEF = 24;        // default width of the event counts
   localparam int DIV_STEPS      = 32;        // quotient bits of the exposure ratio
   localparam int LOG_IN_BITS    = 33;        // widest log argument (alpha + 1.0)
   localparam int LOG_FRAC_BITS  = 24;        // fraction bits of a log2 result
   localparam int LOG_BITS       = 30;        // 6 integer + 24 fraction bits
   localparam int ROOT_BITS      = 32;        // bits of an integer square root

   localparam logic [32:0] ONE_Q24    = 33'h1000000;
   localparam logic [31:0] LG_ONE_Q24 = 32'h18000000;   // log2(2^24) in Q.24
   localparam logic [31:0] LN2_Q32    = 32'hB17217F8;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_ZERO_EXPOSURE = 2'd1,
      STATUS_ZERO_COUNTS   = 2'd2
   } status_type;

   // clamp a signed 64-bit value into signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh000000007FFFFFFF) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sh0000000080000000) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[sv/oos_div.sv]
// oos_div: pipelined restoring divider for alpha = exposure_on * 2^24 / exposure_off,
// one quotient bit per stage, counts and sigma ride along. Uses oos_pkg.

module oos_div import oos_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  adv,
   input  logic [COUNT_BITS-1:0] in_count_on,
   input  logic [COUNT_BITS-1:0] in_count_off,
   input  logic [31:0]           in_exposure_on,
   input  logic [31:0]           in_exposure_off,
   input  logic [11:0]           in_sigma_mult,
   output logic [31:0]           out_alpha,
   output logic [COUNT_BITS-1:0] out_count_on,
   output logic [COUNT_BITS-1:0] out_count_off,
   output logic [11:0]           out_sigma_mult,
   output logic                  out_zero_exp
);

   typedef struct packed {
      logic [31:0]           rem;
      logic [31:0]           divisor;
      logic [31:0]           quo;
      logic [31:0]           dlo;      // dividend bits still to bring down
      logic                  ovf;
      logic                  zexp;
      logic [COUNT_BITS-1:0] con;
      logic [COUNT_BITS-1:0] coff;
      logic [11:0]           sig;
   } div_stage_type;

   div_stage_type stage_ff [DIV_STEPS+1];
   div_stage_type stage_in [DIV_STEPS+1];
   logic [32:0]   trial;

   always_comb begin
      trial = '0;
      stage_in[0].rem     = {8'd0, in_exposure_on[31:8]};
      stage_in[0].divisor = in_exposure_off;
      stage_in[0].quo     = '0;
      stage_in[0].dlo     = {in_exposure_on[7:0], 24'd0};
      stage_in[0].ovf     = {8'd0, in_exposure_on} >= {in_exposure_off, 8'd0};
      stage_in[0].zexp    = (in_exposure_on == '0) || (in_exposure_off == '0);
      stage_in[0].con     = in_count_on;
      stage_in[0].coff    = in_count_off;
      stage_in[0].sig     = in_sigma_mult;
      for (int i = 0; i < DIV_STEPS; i++) begin
         stage_in[i+1]     = stage_ff[i];
         trial             = {stage_ff[i].rem, stage_ff[i].dlo[31]};
         stage_in[i+1].dlo = {stage_ff[i].dlo[30:0], 1'b0};
         if (trial >= {1'b0, stage_ff[i].divisor}) begin
            stage_in[i+1].rem = 32'(trial - {1'b0, stage_ff[i].divisor});
            stage_in[i+1].quo = {stage_ff[i].quo[30:0], 1'b1};
         end else begin
            stage_in[i+1].rem = trial[31:0];
            stage_in[i+1].quo = {stage_ff[i].quo[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   // quotient of 2^32 or more saturates
   assign out_alpha      = stage_ff[DIV_STEPS].ovf ? '1 : stage_ff[DIV_STEPS].quo;
   assign out_count_on   = stage_ff[DIV_STEPS].con;
   assign out_count_off  = stage_ff[DIV_STEPS].coff;
   assign out_sigma_mult = stage_ff[DIV_STEPS].sig;
   assign out_zero_exp   = stage_ff[DIV_STEPS].zexp;

endmodule

[sv/oos_log.sv]
// oos_log: pipelined log2 in Q.24 (truncating): normalize stage, then one
// squaring step per fraction bit. Uses oos_pkg.

module oos_log import oos_pkg::*; (
   input  logic                   clock,
   input  logic                   adv,
   input  logic [LOG_IN_BITS-1:0] in_x,
   output logic [LOG_BITS-1:0]    out_lg
);

   typedef struct packed {
      logic [5:0]               k;
      logic [31:0]              m;
      logic [LOG_FRAC_BITS-1:0] frac;
   } log_stage_type;

   log_stage_type stage_ff [LOG_FRAC_BITS+1];
   log_stage_type stage_in [LOG_FRAC_BITS+1];
   logic [5:0]    k0;
   logic [63:0]   sq;

   always_comb begin
      k0 = '0;
      sq = '0;
      for (int b = 0; b < LOG_IN_BITS; b++) begin
         if (in_x[b]) begin
            k0 = 6'(b);
         end
      end
      stage_in[0].k    = k0;
      stage_in[0].frac = '0;
      if (k0 == 6'd32) begin
         stage_in[0].m = in_x[32:1];
      end else begin
         stage_in[0].m = 32'(64'(in_x) << (6'd31 - k0));
      end
      // mantissa stays in [2^31, 2^32)
      for (int i = 0; i < LOG_FRAC_BITS; i++) begin
         stage_in[i+1] = stage_ff[i];
         sq            = stage_ff[i].m * stage_ff[i].m;
         if (sq[63]) begin
            stage_in[i+1].m    = sq[63:32];
            stage_in[i+1].frac = {stage_ff[i].frac[LOG_FRAC_BITS-2:0], 1'b1};
         end else begin
            stage_in[i+1].m    = sq[62:31];
            stage_in[i+1].frac = {stage_ff[i].frac[LOG_FRAC_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign out_lg = {stage_ff[LOG_FRAC_BITS].k, stage_ff[LOG_FRAC_BITS].frac};

endmodule

[sv/oos_sqrt.sv]
// oos_sqrt: pipelined integer square root of a 64-bit radicand, one root bit
// per stage (digit by digit). Uses oos_pkg.

module oos_sqrt import oos_pkg::*; (
   input  logic                   clock,
   input  logic                   adv,
   input  logic [2*ROOT_BITS-1:0] in_x,
   output logic [ROOT_BITS-1:0]   out_root
);

   typedef struct packed {
      logic [ROOT_BITS+2:0]   rem;
      logic [ROOT_BITS-1:0]   root;
      logic [2*ROOT_BITS-1:0] xs;
   } root_stage_type;

   root_stage_type stage_ff [ROOT_BITS];
   root_stage_type stage_in [ROOT_BITS];
   root_stage_type head;

   function automatic root_stage_type root_step(input root_stage_type s);
      root_stage_type       r;
      logic [ROOT_BITS+2:0] rt;
      logic [ROOT_BITS+2:0] tr;
      rt   = {s.rem[ROOT_BITS:0], s.xs[2*ROOT_BITS-1 -: 2]};
      tr   = {1'b0, s.root, 2'b01};
      r.xs = {s.xs[2*ROOT_BITS-3:0], 2'b00};
      if (rt >= tr) begin
         r.rem  = rt - tr;
         r.root = {s.root[ROOT_BITS-2:0], 1'b1};
      end else begin
         r.rem  = rt;
         r.root = {s.root[ROOT_BITS-2:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      head.rem    = '0;
      head.root   = '0;
      head.xs     = in_x;
      stage_in[0] = root_step(head);
      for (int i = 1; i < ROOT_BITS; i++) begin
         stage_in[i] = root_step(stage_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign out_root = stage_ff[ROOT_BITS-1].root;

endmodule

[sv/on_off_significance.sv]
// on_off_significance: top level of the Li-Ma on/off significance pipeline.
// Uses oos_pkg, oos_div, oos_log and oos_sqrt.
//
//   channel | ports   | direction | transaction
//   --------+---------+-----------+------------------------------------------
//   request | req_*   | in        | counts, exposures, sigma multiple
//   result  | rsp_*   | out       | alpha, excess, deviation, significance,
//           |         |           | interval bounds, status
//
// One transaction per cycle sustained while no result is held; a request reaches the
// result through the divider (33 stages), the log2 lanes (25 stages) with the
// arithmetic around them, and the square-root units (32 stages).
// A stalled result freezes the whole pipeline: every stage advances together,
// so req_stall follows rsp_stall while a result is pending.
// Reset (synchronous) clears only the valid line; data registers are not reset.

module on_off_significance import oos_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COUNT_BITS-1:0] req_count_on,
   input  logic [COUNT_BITS-1:0] req_count_off,
   input  logic [31:0]           req_exposure_on,
   input  logic [31:0]           req_exposure_off,
   input  logic [11:0]           req_sigma_mult,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [31:0]           rsp_ratio_alpha,
   output logic signed [31:0]    rsp_excess_counts,
   output logic [31:0]           rsp_std_deviation,
   output logic [31:0]           rsp_significance,
   output logic signed [31:0]    rsp_interval_low,
   output logic signed [31:0]    rsp_interval_high,
   output logic [1:0]            rsp_status
);

   // stage bookkeeping; times count advances since the request was taken
   localparam int LOG_LAT     = LOG_FRAC_BITS + 1;
   localparam int C_STAGES    = 5;                        // log combine .. radicand
   localparam int SIDE1_DEPTH = LOG_LAT + C_STAGES - 2;   // B3 -> radicand ready
   localparam int C1_TAP      = LOG_LAT - 2;              // side1 tap level with C1
   localparam int LATENCY     = DIV_STEPS + 1 + 3 + SIDE1_DEPTH + ROOT_BITS + 2;
   localparam int PEX_BITS    = 32 + COUNT_BITS;
   localparam int PH_BITS     = 8 + COUNT_BITS;
   localparam int MON_BITS    = COUNT_BITS + 33;
   localparam int NLOGS       = 5;

   // everything an item carries beside the heavy paths
   typedef struct packed {
      logic [31:0]           alpha;
      logic [COUNT_BITS-1:0] con;
      logic [COUNT_BITS-1:0] coff;
      logic [11:0]           sig;
      logic                  bad;      // zero exposure or alpha truncated to 0
      logic                  nz;       // both counts zero
      logic signed [31:0]    ex;
      logic                  sd_fit;
      logic                  sq_pos;
      logic                  sq_fit;
   } item_type;

   logic adv;
   logic [LATENCY-2:0] vld_ff;
   logic rsp_valid_ff;

   // divider outputs
   logic [31:0]           div_alpha;
   logic [COUNT_BITS-1:0] div_con;
   logic [COUNT_BITS-1:0] div_coff;
   logic [11:0]           div_sig;
   logic                  div_zexp;

   // B stages: excess and variance
   item_type              b1_in, b1_ff, b2_in, b2_ff, b3_in, b3_ff;
   logic [PEX_BITS-1:0]   pex_in, pex_ff;
   logic [63:0]           asq_in, asq_ff;
   logic [PEX_BITS-1:0]   pl_in, pl_ff;
   logic [PH_BITS-1:0]    ph_in, ph_ff;
   logic [39:0]           a2;
   logic [72:0]           var_sum;
   logic [63:0]           sdv_in, sdv_ff;

   // log lanes
   logic [LOG_IN_BITS-1:0] lgx_in [NLOGS];
   logic [LOG_IN_BITS-1:0] lgx_ff [NLOGS];
   logic [LOG_BITS-1:0]    lg     [NLOGS];

   // C stages: significance radicand
   logic signed [31:0]         lon_in, lon_ff, loff_in, loff_ff;
   logic signed [MON_BITS-1:0] mon_in, mon_ff, moff_in, moff_ff;
   logic signed [MON_BITS:0]   tsum;
   logic [63:0]                t_in, t_ff;
   logic                       c3_pos_in, c3_pos_ff, c4_pos_ff, c5_pos_ff;
   logic [63:0]                pl2_in, pl2_ff, ph2_in, ph2_ff;
   logic [95:0]                prod;
   logic [63:0]                sqv_in, sqv_ff;
   logic                       c5_fit_in, c5_fit_ff;

   // delay lines
   item_type    side1_ff [SIDE1_DEPTH];
   logic [63:0] sdv1_ff  [SIDE1_DEPTH];
   item_type    side2_in;
   item_type    side2_ff [ROOT_BITS];

   // roots and final stages
   logic [31:0] root_sd, root_sq, sd_fin, sq_fin;
   logic [43:0] wprod;
   item_type    f1_ff;
   logic [31:0] f1_sd_ff, f1_sq_ff;
   logic [35:0] f1_wid_ff;
   logic signed [63:0] wid_s;

   logic [31:0]        rsp_alpha_ff, rsp_sd_ff, rsp_sq_ff;
   logic signed [31:0] rsp_ex_ff, rsp_lo_ff, rsp_hi_ff;
   logic signed [31:0] lo_in, hi_in;
   status_type         rsp_status_ff, status_in;

   // whole pipeline moves unless a finished result is held
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[LATENCY-3:0], req_valid};
         rsp_valid_ff <= vld_ff[LATENCY-2];
      end
   end

   oos_div #(.COUNT_BITS(COUNT_BITS)) u_div (
      .clock           (clock),
      .adv             (adv),
      .in_count_on     (req_count_on),
      .in_count_off    (req_count_off),
      .in_exposure_on  (req_exposure_on),
      .in_exposure_off (req_exposure_off),
      .in_sigma_mult   (req_sigma_mult),
      .out_alpha       (div_alpha),
      .out_count_on    (div_con),
      .out_count_off   (div_coff),
      .out_sigma_mult  (div_sig),
      .out_zero_exp    (div_zexp)
   );

   // B1: alpha products, log arguments
   always_comb begin
      b1_in       = '0;
      b1_in.alpha = div_alpha;
      b1_in.con   = div_con;
      b1_in.coff  = div_coff;
      b1_in.sig   = div_sig;
      b1_in.bad   = div_zexp || (div_alpha == '0);
      b1_in.nz    = (div_con == '0) && (div_coff == '0);
      pex_in      = div_alpha * div_coff;
      asq_in      = div_alpha * div_alpha;
      lgx_in[0]   = LOG_IN_BITS'(div_alpha);
      lgx_in[1]   = LOG_IN_BITS'(div_alpha) + ONE_Q24;
      lgx_in[2]   = LOG_IN_BITS'(div_con);
      lgx_in[3]   = LOG_IN_BITS'(div_coff);
      lgx_in[4]   = LOG_IN_BITS'(div_con) + LOG_IN_BITS'(div_coff);
   end

   // B2: excess, alpha^2 * n_off split into two partial products
   always_comb begin
      b2_in    = b1_ff;
      b2_in.ex = sat32($signed(64'({b1_ff.con, 8'd0})) - $signed(64'(pex_ff >> 16)));
      a2       = asq_ff[63:24];
      pl_in    = a2[31:0] * b1_ff.coff;
      ph_in    = a2[39:32] * b1_ff.coff;
   end

   // B3: variance in Q.16, fits 64 bits unless bit 72 is set
   always_comb begin
      var_sum      = 73'(pl_ff) + (73'(ph_ff) << 32) + (73'(b2_ff.con) << 24);
      b3_in        = b2_ff;
      b3_in.sd_fit = !var_sum[72];
      sdv_in       = var_sum[71:8];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_ff  <= b1_in;
         pex_ff <= pex_in;
         asq_ff <= asq_in;
         lgx_ff <= lgx_in;
         b2_ff  <= b2_in;
         pl_ff  <= pl_in;
         ph_ff  <= ph_in;
         b3_ff  <= b3_in;
         sdv_ff <= sdv_in;
      end
   end

   for (genvar g = 0; g < NLOGS; g++) begin : g_log
      oos_log u_log (
         .clock  (clock),
         .adv    (adv),
         .in_x   (lgx_ff[g]),
         .out_lg (lg[g])
      );
   end

   // C1: the two natural-log terms in log2 units (zero counts null the products)
   assign lon_in  = $signed({2'b00, lg[1]}) - $signed({2'b00, lg[0]})
                  + $signed({2'b00, lg[2]}) - $signed({2'b00, lg[4]});
   assign loff_in = $signed({2'b00, lg[1]}) - $signed(LG_ONE_Q24)
                  + $signed({2'b00, lg[3]}) - $signed({2'b00, lg[4]});

   // C2: weight by counts
   assign mon_in  = $signed({1'b0, side1_ff[C1_TAP].con}) * lon_ff;
   assign moff_in = $signed({1'b0, side1_ff[C1_TAP].coff}) * loff_ff;

   // C3: sum sign-extended to 64 bits, only a positive sum gives a significance
   assign tsum      = mon_ff + moff_ff;
   assign t_in      = 64'(tsum);
   assign c3_pos_in = !t_in[63] && (t_in != '0);

   // C4 / C5: times ln 2 in two halves, then Q.32 radicand
   assign pl2_in    = t_ff[31:0] * LN2_Q32;
   assign ph2_in    = t_ff[63:32] * LN2_Q32;
   assign prod      = 96'(pl2_ff) + {ph2_ff, 32'd0};
   assign c5_fit_in = (prod[95:87] == '0);
   assign sqv_in    = prod[86:23];

   always_ff @(posedge clock) begin
      if (adv) begin
         lon_ff    <= lon_in;
         loff_ff   <= loff_in;
         mon_ff    <= mon_in;
         moff_ff   <= moff_in;
         t_ff      <= t_in;
         c3_pos_ff <= c3_pos_in;
         pl2_ff    <= pl2_in;
         ph2_ff    <= ph2_in;
         c4_pos_ff <= c3_pos_ff;
         sqv_ff    <= sqv_in;
         c5_fit_ff <= c5_fit_in;
         c5_pos_ff <= c4_pos_ff;
      end
   end

   // side line from B3 until the radicand of the significance is ready
   always_ff @(posedge clock) begin
      if (adv) begin
         side1_ff[0] <= b3_ff;
         sdv1_ff[0]  <= sdv_ff;
         for (int i = 1; i < SIDE1_DEPTH; i++) begin
            side1_ff[i] <= side1_ff[i-1];
            sdv1_ff[i]  <= sdv1_ff[i-1];
         end
      end
   end

   always_comb begin
      side2_in        = side1_ff[SIDE1_DEPTH-1];
      side2_in.sq_pos = c5_pos_ff;
      side2_in.sq_fit = c5_fit_ff;
   end

   // both roots run side by side
   oos_sqrt u_sqrt_sd (
      .clock    (clock),
      .adv      (adv),
      .in_x     (sdv1_ff[SIDE1_DEPTH-1]),
      .out_root (root_sd)
   );

   oos_sqrt u_sqrt_sq (
      .clock    (clock),
      .adv      (adv),
      .in_x     (sqv_ff),
      .out_root (root_sq)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         side2_ff[0] <= side2_in;
         for (int i = 1; i < ROOT_BITS; i++) begin
            side2_ff[i] <= side2_ff[i-1];
         end
      end
   end

   // F1: saturate roots, interval half width
   always_comb begin
      sd_fin = side2_ff[ROOT_BITS-1].sd_fit ? root_sd : '1;
      if (!side2_ff[ROOT_BITS-1].sq_pos) begin
         sq_fin = '0;
      end else if (!side2_ff[ROOT_BITS-1].sq_fit) begin
         sq_fin = '1;
      end else begin
         sq_fin = root_sq;
      end
      wprod = side2_ff[ROOT_BITS-1].sig * sd_fin;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ff     <= side2_ff[ROOT_BITS-1];
         f1_sd_ff  <= sd_fin;
         f1_sq_ff  <= sq_fin;
         f1_wid_ff <= wprod[43:8];
      end
   end

   // output register: bounds, zero-exposure override, status
   always_comb begin
      wid_s = $signed(64'(f1_wid_ff));
      lo_in = sat32(64'(f1_ff.ex) - wid_s);
      hi_in = sat32(64'(f1_ff.ex) + wid_s);
      if (f1_ff.bad) begin
         status_in = STATUS_ZERO_EXPOSURE;
      end else if (f1_ff.nz) begin
         status_in = STATUS_ZERO_COUNTS;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_status_ff <= status_in;
         if (f1_ff.bad) begin
            rsp_alpha_ff <= '0;
            rsp_ex_ff    <= '0;
            rsp_sd_ff    <= '0;
            rsp_sq_ff    <= '0;
            rsp_lo_ff    <= '0;
            rsp_hi_ff    <= '0;
         end else begin
            rsp_alpha_ff <= f1_ff.alpha;
            rsp_ex_ff    <= f1_ff.ex;
            rsp_sd_ff    <= f1_sd_ff;
            rsp_sq_ff    <= f1_sq_ff;
            rsp_lo_ff    <= lo_in;
            rsp_hi_ff    <= hi_in;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ratio_alpha   = rsp_alpha_ff;
   assign rsp_excess_counts = rsp_ex_ff;
   assign rsp_std_deviation = rsp_sd_ff;
   assign rsp_significance  = rsp_sq_ff;
   assign rsp_interval_low  = rsp_lo_ff;
   assign rsp_interval_high = rsp_hi_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

[sv/oos_checker.sv]
// oos_checker: port-level assertions for on_off_significance, bound to the
// top level. Uses oos_pkg for the status codes.

module oos_checker import oos_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_ratio_alpha,
   input logic [31:0] rsp_excess_counts,
   input logic [31:0] rsp_std_deviation,
   input logic [31:0] rsp_significance,
   input logic [31:0] rsp_interval_low,
   input logic [31:0] rsp_interval_high,
   input logic [1:0]  rsp_status
);

   // held result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_excess_counts)
         && $stable(rsp_significance) && $stable(rsp_status))
      else $error("result changed while stalled");

   // request side stalls exactly while a result is held
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid |-> req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow held result");

   a_zexp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_ZERO_EXPOSURE |->
         rsp_ratio_alpha == '0 && rsp_excess_counts == '0 && rsp_std_deviation == '0
         && rsp_significance == '0 && rsp_interval_low == '0 && rsp_interval_high == '0)
      else $error("zero exposure result not cleared");

   a_zcnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_ZERO_COUNTS |->
         rsp_ratio_alpha != '0 && rsp_excess_counts == '0 && rsp_std_deviation == '0
         && rsp_significance == '0)
      else $error("zero counts result not zero");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |->
         $signed(rsp_interval_low) <= $signed(rsp_excess_counts)
         && $signed(rsp_excess_counts) <= $signed(rsp_interval_high))
      else $error("interval does not contain excess");

endmodule

bind on_off_significance oos_checker u_oos_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_ratio_alpha   (rsp_ratio_alpha),
   .rsp_excess_counts (rsp_excess_counts),
   .rsp_std_deviation (rsp_std_deviation),
   .rsp_significance  (rsp_significance),
   .rsp_interval_low  (rsp_interval_low),
   .rsp_interval_high (rsp_interval_high),
   .rsp_status        (rsp_status)
);
